@@ rtl/rhc_pkg.sv @@
// Shared widths, types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rhc_pkg;

   // channel and quotient widths
   localparam int CH_W      = 8;
   localparam int QUO_W     = 8;
   localparam int DIFF_W    = CH_W + 1;
   // hue: num < 6*delta <= 1530, dividend 255*num < 2^19
   localparam int HUE_DEN_W = 11;
   localparam int HUE_NUM_W = HUE_DEN_W + QUO_W;
   // saturation: dividend 255*delta < 2^16, divisor is the max channel
   localparam int SAT_DEN_W = CH_W;
   localparam int SAT_NUM_W = CH_W + QUO_W;
   // front end has two stages, the dividers one per quotient bit
   localparam int FRONT_STAGES = 2;
   localparam int LATENCY      = FRONT_STAGES + QUO_W;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // first front stage: max, chroma, sector and signed channel difference
   typedef struct packed {
      logic [CH_W-1:0]          hi;
      logic [CH_W-1:0]          delta;
      sector_type               sector;
      logic signed [DIFF_W-1:0] diff;
   } stage_a_type;

   // second front stage: operands of both divisions
   typedef struct packed {
      logic [CH_W-1:0]      brightness;
      logic [HUE_NUM_W-1:0] hue_num;
      logic [HUE_DEN_W-1:0] hue_den;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [SAT_DEN_W-1:0] sat_den;
   } front_out_type;

endpackage

`default_nettype wire

@@ rtl/rgb_to_hsv_convert_unit.sv @@
// Top level of the 8-bit RGB to HSV converter.
// Depends on rhc_pkg, rhc_front and rhc_divider.
//
// Usage:
//   req channel: one pixel per item, tdata = red[7:0], green[15:8],
//   blue[23:16]. rsp channel: one HSV item per pixel, tdata = hue[7:0],
//   saturation[15:8], brightness[23:16], in the order of the pixels.
//   Ten register stages: two front stages (max/min/sector, then operand
//   forming) and eight divider stages, one quotient bit each, with hue
//   and saturation divided side by side. Throughput is one item per
//   cycle. The whole pipeline advances together; it holds only while
//   the output register is full and rsp_tready is low. Empty slots
//   inside the pipeline hold as well. A stall holds every stage, so no
//   item is lost or repeated. Reset clears all valid bits and holds
//   req_tready low; the block is ready in the first cycle after reset.
//   Grey pixels give hue and saturation of zero.
`default_nettype none

module rgb_to_hsv_convert_unit
   import rhc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // red[7:0], green[15:8], blue[23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata   // hue[7:0], saturation[15:8], brightness[23:16]
);

   logic                en;
   logic [LATENCY-1:0]  valid_ff;
   logic [LATENCY-1:0]  valid_in;
   logic [CH_W-1:0]     bright_ff [QUO_W];
   front_out_type       front_out;
   logic [QUO_W-1:0]    hue;
   logic [QUO_W-1:0]    sat;

   // advance whenever the output slot is free or being taken
   assign en         = !valid_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en && !reset;

   // valid bits travel with the data
   assign valid_in = {valid_ff[LATENCY-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   rhc_front u_front (
      .clock     (clock),
      .en        (en),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .front_out (front_out)
   );

   rhc_divider #(
      .NUM_W (HUE_NUM_W),
      .DEN_W (HUE_DEN_W)
   ) u_hue_div (
      .clock   (clock),
      .en      (en),
      .num_in  (front_out.hue_num),
      .den_in  (front_out.hue_den),
      .quo_out (hue)
   );

   rhc_divider #(
      .NUM_W (SAT_NUM_W),
      .DEN_W (SAT_DEN_W)
   ) u_sat_div (
      .clock   (clock),
      .en      (en),
      .num_in  (front_out.sat_num),
      .den_in  (front_out.sat_den),
      .quo_out (sat)
   );

   // delay brightness alongside the divider stages
   always_ff @(posedge clock) begin
      if (en) begin
         bright_ff[0] <= front_out.brightness;
         for (int i = 1; i < QUO_W; i++) begin
            bright_ff[i] <= bright_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = valid_ff[LATENCY-1];
   assign rsp_tdata  = {bright_ff[QUO_W-1], sat, hue};

   // hue stays below a full circle
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] != 8'hFF))
      else $error("hue reached 255");

   // black pixel is grey: no hue, no saturation
   a_black_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[23:16] == 8'h00) |->
      (rsp_tdata[15:8] == 8'h00 && rsp_tdata[7:0] == 8'h00))
      else $error("black pixel with hue or saturation");

   // zero saturation only for grey, which has zero hue
   a_sat_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[15:8] == 8'h00) |-> (rsp_tdata[7:0] == 8'h00))
      else $error("hue without saturation");

endmodule

`default_nettype wire

@@ rtl/rhc_front.sv @@
// Front end of the converter: finds max, min and sector, then forms the
// dividends and divisors of hue and saturation. Two register stages.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front
   import rhc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [CH_W-1:0] red,
   input  wire logic [CH_W-1:0] green,
   input  wire logic [CH_W-1:0] blue,
   output front_out_type      front_out
);

   stage_a_type   a_in, a_ff;
   front_out_type b_in, b_ff;

   logic [CH_W-1:0]       lo;
   logic [HUE_DEN_W-1:0]  six_d;
   logic [HUE_DEN_W-1:0]  base;
   logic signed [HUE_DEN_W:0] num_s;
   logic [HUE_DEN_W-1:0]  num;

   // pick the sector: red wins ties over green, green over blue
   always_comb begin
      a_in = '0;
      if (red >= green && red >= blue) begin
         a_in.sector = SECT_RED;
         a_in.hi     = red;
         a_in.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         a_in.sector = SECT_GREEN;
         a_in.hi     = green;
         a_in.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         a_in.sector = SECT_BLUE;
         a_in.hi     = blue;
         a_in.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      lo = (red <= green) ? red : green;
      lo = (lo <= blue) ? lo : blue;
      a_in.delta = a_in.hi - lo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
      end
   end

   // form hue numerator from sector offset, wrap negative red sector
   always_comb begin
      six_d = (HUE_DEN_W'(a_ff.delta) << 2) + (HUE_DEN_W'(a_ff.delta) << 1);
      case (a_ff.sector)
         SECT_RED:   base = a_ff.diff[DIFF_W-1] ? six_d : '0;
         SECT_GREEN: base = HUE_DEN_W'(a_ff.delta) << 1;
         SECT_BLUE:  base = HUE_DEN_W'(a_ff.delta) << 2;
         default:    base = '0;
      endcase
      num_s = $signed({1'b0, base}) + (HUE_DEN_W+1)'(a_ff.diff);
      num   = num_s[HUE_DEN_W-1:0];

      b_in.brightness = a_ff.hi;
      if (a_ff.delta == '0) begin
         // grey pixel: zero dividends give zero hue and saturation
         b_in.hue_num = '0;
         b_in.hue_den = HUE_DEN_W'(1);
         b_in.sat_num = '0;
         b_in.sat_den = SAT_DEN_W'(1);
      end else begin
         b_in.hue_num = (HUE_NUM_W'(num) << QUO_W) - HUE_NUM_W'(num);
         b_in.hue_den = six_d;
         b_in.sat_num = (SAT_NUM_W'(a_ff.delta) << QUO_W) - SAT_NUM_W'(a_ff.delta);
         b_in.sat_den = a_ff.hi;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff <= b_in;
      end
   end

   assign front_out = b_ff;

endmodule

`default_nettype wire

@@ rtl/rhc_divider.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QUO_W bits. Depends on rhc_pkg.
`default_nettype none

module rhc_divider
   import rhc_pkg::*;
#(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num_in,
   input  wire logic [DEN_W-1:0] den_in,
   output logic      [QUO_W-1:0] quo_out
);

   localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [W-1:0]     rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int BIT = QUO_W - 1 - k;

      logic [W-1:0]     rem_src;
      logic [W-1:0]     den_sh;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [QUO_W-1:0] quo_in;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_src = W'(num_in);
         assign den_src = den_in;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      // trial subtract of the shifted divisor decides this bit
      assign den_sh = W'(den_src) << BIT;
      assign ge     = (rem_src >= den_sh);

      always_comb begin
         quo_in      = quo_src;
         quo_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k] <= quo_in;
         end
      end

      // carry remainder and divisor only where a later stage needs them
      if (k < QUO_W - 1) begin : g_carry
         logic [W-1:0] rem_in;
         assign rem_in = ge ? (rem_src - den_sh) : rem_src;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_src;
            end
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

@@ tb/sv/hsv_result_check.sv @@
// Checker for the RGB to HSV converter: watches the req and rsp channels,
// predicts HSV for every accepted pixel and compares each result in order.
// Depends on rhc_pkg for the sector type.
`timescale 1ns / 1ps

module hsv_result_check
   import rhc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
   output int               mismatch_count,
   output int               pending_count
);

   // expected HSV words, oldest first
   logic [23:0] hsv_pending [$];
   int          error_total = 0;

   // integer HSV of one pixel; packed as brightness, saturation, hue
   function automatic logic [23:0] pixel_to_hsv(input logic [23:0] pixel);
      logic [7:0]  r, g, b, hi, lo, hue, sat;
      int unsigned delta, num;
      sector_type  sect;
      r = pixel[7:0];
      g = pixel[15:8];
      b = pixel[23:16];
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      delta = 32'(hi - lo);
      hue = '0;
      sat = '0;
      // red wins ties over green, green over blue
      if (r >= g && r >= b) begin
         sect = SECT_RED;
      end else if (g >= b) begin
         sect = SECT_GREEN;
      end else begin
         sect = SECT_BLUE;
      end
      // grey pixels keep hue and saturation at zero
      if (delta != 0) begin
         sat = 8'((255 * delta) / hi);
         case (sect)
            SECT_RED: begin
               // wrap a negative difference by a full circle
               num = (g >= b) ? (g - b) : (6 * delta - (b - g));
            end
            SECT_GREEN: begin
               num = 2 * delta + b - r;
            end
            default: begin
               num = 4 * delta + r - g;
            end
         endcase
         hue = 8'((255 * num) / (6 * delta));
      end
      return {hi, sat, hue};
   endfunction

   // compare each result with the oldest prediction, then queue new pixels
   always @(posedge clock) begin : watch
      logic [23:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (hsv_pending.size() == 0) begin
               $error("unexpected result item: tdata %h", rsp_tdata);
               error_total++;
            end else begin
               want = hsv_pending.pop_front();
               if (rsp_tdata[7:0] !== want[7:0]) begin
                  $error("hue: expected %0d, actual %0d", want[7:0], rsp_tdata[7:0]);
                  error_total++;
               end
               if (rsp_tdata[15:8] !== want[15:8]) begin
                  $error("saturation: expected %0d, actual %0d",
                         want[15:8], rsp_tdata[15:8]);
                  error_total++;
               end
               if (rsp_tdata[23:16] !== want[23:16]) begin
                  $error("brightness: expected %0d, actual %0d",
                         want[23:16], rsp_tdata[23:16]);
                  error_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            hsv_pending.push_back(pixel_to_hsv(req_tdata));
         end
      end
      mismatch_count <= error_total;
      pending_count  <= hsv_pending.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus,
// random receiver stalls and the verdict. Depends on rhc_pkg, the block
// rgb_to_hsv_convert_unit and the checker hsv_result_check.
`timescale 1ns / 1ps

module testbench
   import rhc_pkg::*;
();

   localparam int PHASE_ITEMS = 283;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // hue[7:0], saturation[15:8], brightness[23:16]

   int mismatch_count;
   int pending_count;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   const logic [7:0] extremes [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

   always #6 clock = ~clock;

   rgb_to_hsv_convert_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hsv_result_check hsv_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // stall the receiver at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // hold one pixel on the req channel until it is accepted
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // random pixels, biased toward grey, ties for the max and extremes
   task automatic send_random_pixel();
      logic [7:0] r, g, b;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            g = r;
            b = r;
         end
         1: g = r;
         2: b = g;
         3: b = r;
         4: begin
            r = extremes[$urandom_range(0, 3)];
            g = extremes[$urandom_range(0, 3)];
            b = extremes[$urandom_range(0, 3)];
         end
         5: begin
            // small chroma around a random level
            g = 8'(r + $urandom_range(0, 2));
            b = 8'(r - $urandom_range(0, 2));
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   // overall time limit
   initial begin
      #2_400_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed pixels: extremes, every sector, ties and the red wrap
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd1,   8'd0,   8'd1);
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd200, 8'd50,  8'd100);
      send_pixel(8'd50,  8'd200, 8'd100);
      send_pixel(8'd100, 8'd200, 8'd50);
      send_pixel(8'd100, 8'd50,  8'd200);
      send_pixel(8'd50,  8'd100, 8'd200);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd170, 8'd85,  8'd255);
      drain_results();

      // random phases under different idle and stall rates
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_pixel();
         end
         drain_results();
      end

      // let the pipeline settle before the verdict
      recv_stall_pct = 0;
      repeat (LATENCY + 4) @(posedge clock);
      if (pending_count != 0) begin
         $error("%0d expected results never arrived", pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
